// File: src/i2cms_pkg.sv
// ============================================================================
// I2C master bit sequencer package
// Shared constants, item types, phase action codes and small lookup helpers.
// ============================================================================
package i2cms_pkg;

    // Width of the per-phase tick counter.
    localparam int TICK_W = 16;
    // Width of the phase_ticks configuration register.
    localparam int CFG_W = 16;
    // Width used to compare the counter against the phase limit.
    localparam int LIM_W = (TICK_W > CFG_W) ? TICK_W : CFG_W;
    // Phase index width; the longest series has 25 phases.
    localparam int IDX_W = 5;
    localparam int BYTE_W = 8;
    localparam int REQ_W = 3;

    // Reset value of phase_ticks.
    localparam logic [CFG_W-1:0] PHASE_TICKS_RST = CFG_W'(720);

    // Command codes carried by req_type.
    typedef enum logic [REQ_W-1:0] {
        REQ_START   = 3'd0,
        REQ_STOP    = 3'd1,
        REQ_TX_BYTE = 3'd2,
        REQ_RX_BYTE = 3'd3,
        REQ_TX_ACK  = 3'd4,
        REQ_RX_ACK  = 3'd5
    } req_t;

    // What one phase does.
    typedef enum logic [1:0] {
        ACT_SCL  = 2'd0,
        ACT_SDA  = 2'd1,
        ACT_READ = 2'd2
    } act_kind_t;

    typedef struct packed {
        act_kind_t kind;
        logic      val;
    } phase_act_t;

    // Input item: one clock tick of the sequencer.
    typedef struct packed {
        logic              cmd_valid;
        logic [REQ_W-1:0]  req_type;
        logic [BYTE_W-1:0] tx_byte;
        logic              ack_level;
        logic              sda_in;
    } in_item_t;

    // Result item: pin levels and status after the tick.
    typedef struct packed {
        logic              scl_out;
        logic              sda_out;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] rx_byte;
        logic              rx_ack;
        logic              cmd_rejected;
    } out_item_t;

    // Number of phases in each command's series.
    function automatic logic [IDX_W-1:0] series_len(input logic [REQ_W-1:0] cmd);
        logic [IDX_W-1:0] len;
        case (cmd)
            REQ_START:   len = IDX_W'(4);
            REQ_STOP:    len = IDX_W'(3);
            REQ_TX_BYTE: len = IDX_W'(24);
            REQ_RX_BYTE: len = IDX_W'(25);
            REQ_TX_ACK:  len = IDX_W'(3);
            REQ_RX_ACK:  len = IDX_W'(4);
            default:     len = IDX_W'(4);
        endcase
        return len;
    endfunction

    // Quotient by three for a 5-bit value: (v * 11) >> 5 is exact for v < 32.
    function automatic logic [3:0] div3(input logic [IDX_W-1:0] v);
        logic [8:0] prod;
        prod = 9'(v) * 9'd11;
        return prod[8:5];
    endfunction

endpackage

// File: src/i2cms_phase_dec.sv
// ============================================================================
// I2C master phase decoder
// Maps a command and a phase index to the pin write or SDA read it performs.
// ============================================================================
module i2cms_phase_dec (
    input  logic [i2cms_pkg::REQ_W-1:0]  cmd,
    input  logic [i2cms_pkg::IDX_W-1:0]  idx,
    input  logic [i2cms_pkg::BYTE_W-1:0] tx,
    input  logic                         ack,
    output i2cms_pkg::phase_act_t        act
);

    logic [3:0]                    q_tx;
    logic [i2cms_pkg::IDX_W-1:0]   sub_tx;
    logic [i2cms_pkg::IDX_W-1:0]   idx_m1;
    logic [3:0]                    q_rx;
    logic [i2cms_pkg::IDX_W-1:0]   sub_rx;
    logic [2:0]                    bit_sel;

    // Bit slot and position within the slot for the byte commands.
    always_comb
    begin
        q_tx    = i2cms_pkg::div3(idx);
        sub_tx  = idx - ({1'b0, q_tx} + {q_tx, 1'b0});
        idx_m1  = idx - i2cms_pkg::IDX_W'(1);
        q_rx    = i2cms_pkg::div3(idx_m1);
        sub_rx  = idx_m1 - ({1'b0, q_rx} + {q_rx, 1'b0});
        bit_sel = 3'd7 - q_tx[2:0];
    end

    // Phase action lookup per command.
    always_comb
    begin
        act.kind = i2cms_pkg::ACT_SCL;
        act.val  = 1'b0;
        case (cmd)
            i2cms_pkg::REQ_START:
            begin
                act.kind = idx[0] ? i2cms_pkg::ACT_SCL : i2cms_pkg::ACT_SDA;
                act.val  = (idx < i2cms_pkg::IDX_W'(2));
            end
            i2cms_pkg::REQ_STOP:
            begin
                act.kind = (idx == i2cms_pkg::IDX_W'(1)) ? i2cms_pkg::ACT_SCL
                                                          : i2cms_pkg::ACT_SDA;
                act.val  = (idx != '0);
            end
            i2cms_pkg::REQ_TX_BYTE:
            begin
                if (sub_tx == '0)
                begin
                    act.kind = i2cms_pkg::ACT_SDA;
                    act.val  = tx[bit_sel];
                end
                else
                begin
                    act.kind = i2cms_pkg::ACT_SCL;
                    act.val  = (sub_tx == i2cms_pkg::IDX_W'(1));
                end
            end
            i2cms_pkg::REQ_RX_BYTE:
            begin
                if (idx == '0)
                begin
                    act.kind = i2cms_pkg::ACT_SDA;
                    act.val  = 1'b1;
                end
                else if (sub_rx == i2cms_pkg::IDX_W'(1))
                begin
                    act.kind = i2cms_pkg::ACT_READ;
                end
                else
                begin
                    act.kind = i2cms_pkg::ACT_SCL;
                    act.val  = (sub_rx == '0);
                end
            end
            i2cms_pkg::REQ_TX_ACK:
            begin
                if (idx == '0)
                begin
                    act.kind = i2cms_pkg::ACT_SDA;
                    act.val  = ack;
                end
                else
                begin
                    act.kind = i2cms_pkg::ACT_SCL;
                    act.val  = (idx == i2cms_pkg::IDX_W'(1));
                end
            end
            default:
            begin
                // Receive ack series.
                if (idx == '0)
                begin
                    act.kind = i2cms_pkg::ACT_SDA;
                    act.val  = 1'b1;
                end
                else if (idx == i2cms_pkg::IDX_W'(2))
                begin
                    act.kind = i2cms_pkg::ACT_READ;
                end
                else
                begin
                    act.kind = i2cms_pkg::ACT_SCL;
                    act.val  = (idx == i2cms_pkg::IDX_W'(1));
                end
            end
        endcase
    end

endmodule

// File: src/i2cms_step.sv
// ============================================================================
// I2C master sequencer state
// Holds the line and command state and advances it by one tick per item.
// ============================================================================
module i2cms_step (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  i2cms_pkg::in_item_t          item,
    input  logic [i2cms_pkg::CFG_W-1:0]  phase_ticks,
    output i2cms_pkg::out_item_t         res
);

    logic                          scl_reg, scl_next;
    logic                          sda_reg, sda_next;
    logic [i2cms_pkg::REQ_W-1:0]   cmd_reg, cmd_next;
    logic                          running_reg, running_next;
    logic [i2cms_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [i2cms_pkg::TICK_W-1:0]  tick_reg, tick_next;
    logic [i2cms_pkg::BYTE_W-1:0]  shift_reg, shift_next;
    logic                          ack_store_reg, ack_store_next;
    logic [i2cms_pkg::BYTE_W-1:0]  tx_hold_reg, tx_hold_next;
    logic                          ack_hold_reg, ack_hold_next;

    logic [i2cms_pkg::LIM_W-1:0]   lim;
    logic [i2cms_pkg::LIM_W-1:0]   cnt_max;
    logic                          expired;
    logic [i2cms_pkg::IDX_W-1:0]   nxt_idx;
    logic                          start_ok;
    logic                          step_ok;
    logic                          do_act;
    logic [i2cms_pkg::REQ_W-1:0]   sel_cmd;
    logic [i2cms_pkg::IDX_W-1:0]   sel_idx;
    logic [i2cms_pkg::BYTE_W-1:0]  sel_tx;
    logic                          sel_ack;
    logic [i2cms_pkg::BYTE_W-1:0]  shift_base;
    logic                          done;
    logic                          rejected;
    i2cms_pkg::phase_act_t         act;

    // Phase length: zero counts as one, and the counter range caps it.
    always_comb
    begin
        cnt_max = i2cms_pkg::LIM_W'({i2cms_pkg::TICK_W{1'b1}});
        lim     = i2cms_pkg::LIM_W'(phase_ticks);
        if (lim == '0)
        begin
            lim = i2cms_pkg::LIM_W'(1);
        end
        if (lim > cnt_max)
        begin
            lim = cnt_max;
        end
        expired = (i2cms_pkg::LIM_W'(tick_reg) >= lim);
    end

    // Choose which phase, if any, acts on this tick.
    always_comb
    begin
        nxt_idx  = idx_reg + i2cms_pkg::IDX_W'(1);
        start_ok = !running_reg && item.cmd_valid &&
                   (item.req_type <= i2cms_pkg::REQ_RX_ACK);
        step_ok  = running_reg && expired &&
                   (nxt_idx < i2cms_pkg::series_len(cmd_reg));
        do_act   = start_ok || step_ok;
        sel_cmd  = running_reg ? cmd_reg      : item.req_type;
        sel_idx  = running_reg ? nxt_idx      : '0;
        sel_tx   = running_reg ? tx_hold_reg  : item.tx_byte;
        sel_ack  = running_reg ? ack_hold_reg : item.ack_level;
    end

    i2cms_phase_dec u_phase_dec (
        .cmd (sel_cmd),
        .idx (sel_idx),
        .tx  (sel_tx),
        .ack (sel_ack),
        .act (act)
    );

    // Next state for one tick.
    always_comb
    begin
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        cmd_next       = cmd_reg;
        running_next   = running_reg;
        idx_next       = idx_reg;
        tick_next      = tick_reg;
        ack_store_next = ack_store_reg;
        tx_hold_next   = tx_hold_reg;
        ack_hold_next  = ack_hold_reg;
        done           = 1'b0;
        rejected       = 1'b0;
        shift_base     = (start_ok && (item.req_type == i2cms_pkg::REQ_RX_BYTE)) ?
                         '0 : shift_reg;

        if (running_reg)
        begin
            rejected = item.cmd_valid;
            if (expired)
            begin
                if (step_ok)
                begin
                    idx_next  = nxt_idx;
                    tick_next = i2cms_pkg::TICK_W'(1);
                end
                else
                begin
                    running_next = 1'b0;
                    done         = 1'b1;
                    idx_next     = '0;
                    tick_next    = '0;
                end
            end
            else
            begin
                tick_next = tick_reg + i2cms_pkg::TICK_W'(1);
            end
        end
        else if (item.cmd_valid)
        begin
            if (start_ok)
            begin
                cmd_next      = item.req_type;
                tx_hold_next  = item.tx_byte;
                ack_hold_next = item.ack_level;
                running_next  = 1'b1;
                idx_next      = '0;
                tick_next     = i2cms_pkg::TICK_W'(1);
            end
            else
            begin
                rejected = 1'b1;
            end
        end

        // Apply the selected phase action.
        shift_next = shift_base;
        if (do_act)
        begin
            case (act.kind)
                i2cms_pkg::ACT_SCL: scl_next = act.val;
                i2cms_pkg::ACT_SDA: sda_next = act.val;
                i2cms_pkg::ACT_READ:
                begin
                    if (sel_cmd == i2cms_pkg::REQ_RX_BYTE)
                    begin
                        shift_next = {shift_base[i2cms_pkg::BYTE_W-2:0], item.sda_in};
                    end
                    else
                    begin
                        ack_store_next = item.sda_in;
                    end
                end
                default: ;
            endcase
        end
    end

    // The result shows the state after this tick.
    always_comb
    begin
        res.scl_out      = scl_next;
        res.sda_out      = sda_next;
        res.busy_res     = running_next;
        res.done_res     = done;
        res.rx_byte      = shift_next;
        res.rx_ack       = ack_store_next;
        res.cmd_rejected = rejected;
    end

    // State registers advance once per processed item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            cmd_reg       <= '0;
            running_reg   <= 1'b0;
            idx_reg       <= '0;
            tick_reg      <= '0;
            shift_reg     <= '0;
            ack_store_reg <= 1'b0;
            tx_hold_reg   <= '0;
            ack_hold_reg  <= 1'b0;
        end
        else if (adv)
        begin
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            cmd_reg       <= cmd_next;
            running_reg   <= running_next;
            idx_reg       <= idx_next;
            tick_reg      <= tick_next;
            shift_reg     <= shift_next;
            ack_store_reg <= ack_store_next;
            tx_hold_reg   <= tx_hold_next;
            ack_hold_reg  <= ack_hold_next;
        end
    end

endmodule

// File: src/i2c_master_bit_sequencer_core.sv
// ============================================================================
// I2C master bit sequencer core
// Runs start, stop, byte and ack commands as timed open-drain pin phases.
// ============================================================================
//  Channel   Signals                        Direction  Transfer
//  item      item_valid/item_ready/item     in         valid and ready high
//  result    result_valid/result_ready/...  out        valid and ready high
//  cfg       cfg_we/cfg_wdata               in         write on cfg_we
//
// One item is taken per cycle unless a waiting result is stalled; each item
// is held in the input register, then passes once through the step logic
// into the result register. Reset leaves both registers empty, lines released
// and phase_ticks at 720. When a result waits with result_ready low it holds,
// the input register fills, and then item_ready drops.
module i2c_master_bit_sequencer_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  i2cms_pkg::in_item_t          item,
    output logic                         result_valid,
    input  logic                         result_ready,
    output i2cms_pkg::out_item_t         result,
    input  logic                         cfg_we,
    input  logic [i2cms_pkg::CFG_W-1:0]  cfg_wdata
);

    logic                          in_valid_reg, in_valid_next;
    i2cms_pkg::in_item_t           in_item_reg;
    logic                          out_valid_reg, out_valid_next;
    i2cms_pkg::out_item_t          out_item_reg;
    logic [i2cms_pkg::CFG_W-1:0]   phase_ticks_reg;
    logic                          load_out;
    logic                          adv;
    logic                          accept;
    i2cms_pkg::out_item_t          step_res;

    // Handshake control between the input and result registers.
    always_comb
    begin
        load_out       = !out_valid_reg || result_ready;
        adv            = in_valid_reg && load_out;
        item_ready     = !in_valid_reg || load_out;
        accept         = item_valid && item_ready;
        in_valid_next  = accept ? 1'b1 : (adv ? 1'b0 : in_valid_reg);
        out_valid_next = load_out ? in_valid_reg : out_valid_reg;
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= i2cms_pkg::PHASE_TICKS_RST;
        end
        else if (cfg_we)
        begin
            phase_ticks_reg <= cfg_wdata;
        end
    end

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= item;
        end
        if (adv)
        begin
            out_item_reg <= step_res;
        end
    end

    i2cms_step u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .item        (in_item_reg),
        .phase_ticks (phase_ticks_reg),
        .res         (step_res)
    );

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

endmodule

// File: src/i2cms_checker.sv
// ============================================================================
// I2C master bit sequencer checker
// Port-level assertions, attached to the core by a bind statement.
// ============================================================================
module i2cms_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_ready,
    input  logic                 result_valid,
    input  logic                 result_ready,
    input  i2cms_pkg::out_item_t result
);

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped while stalled");

    // A finished command is never reported as still running.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.done_res |-> !result.busy_res)
        else $error("done and busy both set");

    // With no result waiting, the block always takes an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> item_ready)
        else $error("item refused with empty result register");

    // A stalled result keeps its payload until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result))
        else $error("result payload changed while stalled");

endmodule

bind i2c_master_bit_sequencer_core i2cms_checker u_i2cms_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

// File: sim/tb_i2c_master_bit_sequencer_core.sv
`timescale 1ns / 1ps
// ============================================================================
// Testbench for the I2C master bit sequencer core
// Streams clock ticks carrying start, stop, byte and ack commands through the
// item channel and checks every result item against a cycle-exact line model.
// Covers several phase lengths, including the zero and full-scale settings,
// under random sender gaps and receiver stalls.
// ============================================================================
module tb_i2c_master_bit_sequencer_core;

    localparam int CLK_PERIOD  = 8;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int IDLE_PCT    = 54;
    localparam int BOTH_PCT    = 23;

    // Shadow of the sequencer state plus the flags of the last tick.
    typedef struct packed {
        logic        scl;
        logic        sda;
        logic        running;
        logic [2:0]  cmd;
        logic [4:0]  idx;
        logic [15:0] ticks;
        logic [7:0]  shreg;
        logic        ack_rd;
        logic [7:0]  tx_hold;
        logic        ack_hold;
        logic        done;
        logic        rej;
    } line_state_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           item_valid = 1'b0;
    logic                           item_ready;
    i2cms_pkg::in_item_t            item = '0;
    logic                           result_valid;
    logic                           result_ready = 1'b0;
    i2cms_pkg::out_item_t           result;
    logic                           cfg_we = 1'b0;
    logic [i2cms_pkg::CFG_W-1:0]    cfg_wdata = '0;

    i2cms_pkg::in_item_t            tick_queue[$];
    i2cms_pkg::out_item_t           expected_results[$];
    line_state_t                    gen_state;
    line_state_t                    pred_state;
    logic [i2cms_pkg::CFG_W-1:0]    phase_ticks_cfg;
    int                             send_idle_pct = 0;
    int                             stall_pct = 0;
    int                             mismatch_count = 0;
    int                             cycle_count = 0;

    i2c_master_bit_sequencer_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Line model
    // ------------------------------------------------------------------------

    function automatic line_state_t idle_lines();
        line_state_t st;
        st = '0;
        st.scl = 1'b1;
        st.sda = 1'b1;
        return st;
    endfunction

    function automatic int phase_count(input logic [2:0] cmd);
        case (cmd)
            i2cms_pkg::REQ_START:   return 4;
            i2cms_pkg::REQ_STOP:    return 3;
            i2cms_pkg::REQ_TX_BYTE: return 24;
            i2cms_pkg::REQ_RX_BYTE: return 25;
            i2cms_pkg::REQ_TX_ACK:  return 3;
            default:                return 4;
        endcase
    endfunction

    function automatic int phase_limit(input logic [i2cms_pkg::CFG_W-1:0] cfg);
        return (cfg == '0) ? 1 : int'(cfg);
    endfunction

    // True when the next tick closes the running command.
    function automatic logic ends_now(input line_state_t st,
                                      input logic [i2cms_pkg::CFG_W-1:0] cfg);
        return st.running && (int'(st.ticks) >= phase_limit(cfg))
            && (int'(st.idx) + 1 >= phase_count(st.cmd));
    endfunction

    // Carry out the pin write or SDA read of one phase.
    function automatic line_state_t run_phase(input line_state_t st, input logic [4:0] idx,
                                              input logic sda_in);
        i2cms_pkg::act_kind_t kind;
        logic                 val;
        int                   q;
        int                   sub;
        kind = i2cms_pkg::ACT_SCL;
        val  = 1'b0;
        case (st.cmd)
            i2cms_pkg::REQ_START:
            begin
                kind = idx[0] ? i2cms_pkg::ACT_SCL : i2cms_pkg::ACT_SDA;
                val  = (idx < 5'd2);
            end
            i2cms_pkg::REQ_STOP:
            begin
                kind = (idx == 5'd1) ? i2cms_pkg::ACT_SCL : i2cms_pkg::ACT_SDA;
                val  = (idx != 5'd0);
            end
            i2cms_pkg::REQ_TX_BYTE:
            begin
                q   = (int'(idx) / 3) % 8;
                sub = int'(idx) % 3;
                if (sub == 0)
                begin
                    kind = i2cms_pkg::ACT_SDA;
                    val  = st.tx_hold[7 - q];
                end
                else
                begin
                    kind = i2cms_pkg::ACT_SCL;
                    val  = (sub == 1);
                end
            end
            i2cms_pkg::REQ_RX_BYTE:
            begin
                if (idx == 5'd0)
                begin
                    kind = i2cms_pkg::ACT_SDA;
                    val  = 1'b1;
                end
                else
                begin
                    sub = (int'(idx) - 1) % 3;
                    if (sub == 1)
                        kind = i2cms_pkg::ACT_READ;
                    else
                    begin
                        kind = i2cms_pkg::ACT_SCL;
                        val  = (sub == 0);
                    end
                end
            end
            i2cms_pkg::REQ_TX_ACK:
            begin
                if (idx == 5'd0)
                begin
                    kind = i2cms_pkg::ACT_SDA;
                    val  = st.ack_hold;
                end
                else
                begin
                    kind = i2cms_pkg::ACT_SCL;
                    val  = (idx == 5'd1);
                end
            end
            default:
            begin
                if (idx == 5'd0)
                begin
                    kind = i2cms_pkg::ACT_SDA;
                    val  = 1'b1;
                end
                else if (idx == 5'd2)
                    kind = i2cms_pkg::ACT_READ;
                else
                begin
                    kind = i2cms_pkg::ACT_SCL;
                    val  = (idx == 5'd1);
                end
            end
        endcase
        case (kind)
            i2cms_pkg::ACT_SCL: st.scl = val;
            i2cms_pkg::ACT_SDA: st.sda = val;
            default:
            begin
                if (st.cmd == i2cms_pkg::REQ_RX_BYTE)
                    st.shreg = {st.shreg[6:0], sda_in};
                else
                    st.ack_rd = sda_in;
            end
        endcase
        return st;
    endfunction

    // Advance the sequencer by one tick.
    function automatic line_state_t seq_step(input line_state_t st,
                                             input i2cms_pkg::in_item_t it,
                                             input logic [i2cms_pkg::CFG_W-1:0] cfg);
        st.done = 1'b0;
        st.rej  = 1'b0;
        if (st.running)
        begin
            // Busy is judged before the tick, so even the finishing tick rejects.
            if (it.cmd_valid)
                st.rej = 1'b1;
            if (int'(st.ticks) >= phase_limit(cfg))
            begin
                if (int'(st.idx) + 1 >= phase_count(st.cmd))
                begin
                    st.running = 1'b0;
                    st.done    = 1'b1;
                    st.idx     = '0;
                    st.ticks   = '0;
                end
                else
                begin
                    st.idx   = st.idx + 5'd1;
                    st.ticks = 16'd1;
                    st       = run_phase(st, st.idx, it.sda_in);
                end
            end
            else
                st.ticks = st.ticks + 16'd1;
        end
        else if (it.cmd_valid)
        begin
            if (it.req_type > i2cms_pkg::REQ_RX_ACK)
                st.rej = 1'b1;
            else
            begin
                st.cmd      = it.req_type;
                st.tx_hold  = it.tx_byte;
                st.ack_hold = it.ack_level;
                if (it.req_type == i2cms_pkg::REQ_RX_BYTE)
                    st.shreg = '0;
                st.running = 1'b1;
                st.idx     = '0;
                st.ticks   = 16'd1;
                st         = run_phase(st, 5'd0, it.sda_in);
            end
        end
        return st;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: presents queued ticks and records the expected result of each.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_items
        i2cms_pkg::out_item_t want;
        logic                 holding;
        if (!rst_n)
            item_valid <= 1'b0;
        else
        begin
            holding = item_valid;
            if (item_valid && item_ready)
            begin
                pred_state = seq_step(pred_state, item, phase_ticks_cfg);
                want.scl_out      = pred_state.scl;
                want.sda_out      = pred_state.sda;
                want.busy_res     = pred_state.running;
                want.done_res     = pred_state.done;
                want.rx_byte      = pred_state.shreg;
                want.rx_ack       = pred_state.ack_rd;
                want.cmd_rejected = pred_state.rej;
                expected_results.push_back(want);
                holding = 1'b0;
            end
            if (!holding)
            begin
                if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    item       <= tick_queue.pop_front();
                    item_valid <= 1'b1;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each accepted result against the oldest expectation.
    // ------------------------------------------------------------------------
    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch_results
        i2cms_pkg::out_item_t want;
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result with nothing expected, actual %h", $time, result);
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("scl_out", want.scl_out, result.scl_out);
                    compare_field("sda_out", want.sda_out, result.sda_out);
                    compare_field("busy_res", want.busy_res, result.busy_res);
                    compare_field("done_res", want.done_res, result.done_res);
                    compare_field("rx_byte", want.rx_byte, result.rx_byte);
                    compare_field("rx_ack", want.rx_ack, result.rx_ack);
                    compare_field("cmd_rejected", want.cmd_rejected, result.cmd_rejected);
                end
            end
            result_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic i2cms_pkg::in_item_t cmd_tick(input logic valid, input logic [2:0] req,
                                                     input logic [7:0] txb, input logic ack,
                                                     input logic sda);
        i2cms_pkg::in_item_t it;
        it.cmd_valid = valid;
        it.req_type  = req;
        it.tx_byte   = txb;
        it.ack_level = ack;
        it.sda_in    = sda;
        return it;
    endfunction

    // Queue one tick and keep the generator's view of the sequencer current.
    task automatic queue_tick(input i2cms_pkg::in_item_t it);
        tick_queue.push_back(it);
        gen_state = seq_step(gen_state, it, phase_ticks_cfg);
    endtask

    // Let the running command finish; optionally hit its finishing tick.
    task automatic drain(input logic poke_done);
        while (gen_state.running)
            queue_tick(cmd_tick(poke_done && ends_now(gen_state, phase_ticks_cfg),
                                3'($urandom_range(7)), 8'($urandom_range(255)),
                                1'($urandom_range(1)), 1'($urandom_range(1))));
    endtask

    // Wait until no item is pending, in flight or awaiting its result.
    task automatic wait_idle();
        @(negedge clk);
        while (tick_queue.size() != 0 || item_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_phase_ticks(input logic [i2cms_pkg::CFG_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
        phase_ticks_cfg = value;
    endtask

    // One random phase: mostly well-formed commands issued while idle,
    // with stray and undefined commands mixed in.
    task automatic run_random(input logic [i2cms_pkg::CFG_W-1:0] ticks, input int count,
                              input int send_pct, input int stall);
        i2cms_pkg::in_item_t it;
        int                  roll;
        write_phase_ticks(ticks);
        send_idle_pct = send_pct;
        stall_pct     = stall;
        for (int i = 0; i < count; i++)
        begin
            // Halfway through, the sender holds off until all results are in.
            if (i == count / 2)
                wait_idle();
            it.req_type  = 3'($urandom_range(7));
            it.tx_byte   = 8'($urandom_range(255));
            it.ack_level = 1'($urandom_range(1));
            it.sda_in    = 1'($urandom_range(1));
            if (!gen_state.running)
            begin
                roll = $urandom_range(99);
                it.cmd_valid = (roll < 65);
                if (roll < 60)
                    it.req_type = 3'($urandom_range(int'(i2cms_pkg::REQ_RX_ACK)));
            end
            else if (ends_now(gen_state, phase_ticks_cfg))
                it.cmd_valid = ($urandom_range(3) == 0);
            else
                it.cmd_valid = ($urandom_range(19) == 0);
            queue_tick(it);
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        gen_state       = idle_lines();
        pred_state      = idle_lines();
        phase_ticks_cfg = i2cms_pkg::PHASE_TICKS_RST;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // A start under the reset phase length, with a stop issued while busy.
        queue_tick(cmd_tick(1'b1, i2cms_pkg::REQ_START, 8'hFF, 1'b1, 1'b1));
        queue_tick(cmd_tick(1'b1, i2cms_pkg::REQ_STOP, 8'h00, 1'b0, 1'b0));
        queue_tick(cmd_tick(1'b0, 3'd7, 8'hFF, 1'b1, 1'b1));
        wait_idle();

        // Zero phase length runs as one tick per phase; finish the start.
        write_phase_ticks('0);
        drain(1'b1);
        // Undefined request types while idle.
        queue_tick(cmd_tick(1'b1, 3'd7, 8'h00, 1'b0, 1'b0));
        queue_tick(cmd_tick(1'b1, 3'd6, 8'hFF, 1'b1, 1'b1));
        // Start, stop, both ack commands (ack transmit twice) and a byte transmit, with commands on finishing ticks.
        queue_tick(cmd_tick(1'b1, i2cms_pkg::REQ_START, 8'h00, 1'b0, 1'b1));
        drain(1'b1);
        queue_tick(cmd_tick(1'b1, i2cms_pkg::REQ_STOP, 8'hFF, 1'b1, 1'b0));
        drain(1'b0);
        queue_tick(cmd_tick(1'b1, i2cms_pkg::REQ_TX_ACK, 8'h00, 1'b1, 1'b1));
        drain(1'b0);
        queue_tick(cmd_tick(1'b1, i2cms_pkg::REQ_RX_ACK, 8'hFF, 1'b0, 1'b0));
        drain(1'b1);
        queue_tick(cmd_tick(1'b1, i2cms_pkg::REQ_TX_ACK, 8'hFF, 1'b0, 1'b0));
        drain(1'b0);
        queue_tick(cmd_tick(1'b1, i2cms_pkg::REQ_TX_BYTE, 8'hA5, 1'b0, 1'b1));
        wait_idle();

        // Random phases over several phase lengths and idling patterns.
        run_random(16'd1, 300, 0, 0);
        run_random(16'd2, 250, IDLE_PCT, 0);
        run_random(16'd3, 250, 0, IDLE_PCT);
        run_random(16'($urandom_range(6, 1)), 200, BOTH_PCT, BOTH_PCT);
        run_random('0, 120, IDLE_PCT, 0);
        // Full-scale phase length: a command starts and stays in its first phase.
        run_random(16'hFFFF, 120, 0, 0);
        run_random(16'd1, 120, BOTH_PCT, BOTH_PCT);

        wait_idle();
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: filelist.f
src/i2cms_pkg.sv
src/i2cms_phase_dec.sv
src/i2cms_step.sv
src/i2c_master_bit_sequencer_core.sv
src/i2cms_checker.sv
sim/tb_i2c_master_bit_sequencer_core.sv
